// ===== sv/volume_outlier_neighbour_fill_defines.svh =====
// assertion macros for the outlier fill block
// used by the top level only; expects clk and rst_n in scope
`ifndef VOLUME_OUTLIER_NEIGHBOUR_FILL_DEFINES_SVH
`define VOLUME_OUTLIER_NEIGHBOUR_FILL_DEFINES_SVH

// same-cycle implication
`define VONF_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define VONF_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== sv/vonf_pkg.sv =====
// shared types and constants for the outlier fill block
// no dependencies
package vonf_pkg;

    localparam int AXIS_BINS  = 32;
    localparam int VALUE_BITS = 24;
    localparam int COORD_W    = $clog2(AXIS_BINS);
    localparam int ADDR_W     = 3 * COORD_W;
    localparam int DEPTH      = AXIS_BINS * AXIS_BINS * AXIS_BINS;
    localparam int RAD_W      = 6;
    localparam int CNT_W      = ADDR_W;
    localparam int SUM_W      = VALUE_BITS + CNT_W + 1;
    localparam int CFG_IDX_W  = 2;

    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    localparam logic [CFG_IDX_W-1:0] REG_LOW_LIMIT  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HIGH_LIMIT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_RADIUS = 2'd2;

    typedef struct packed {
        logic                         cmd;
        logic [4:0]                   x;
        logic [4:0]                   y;
        logic [4:0]                   z;
        logic signed [VALUE_BITS-1:0] bin_value;
    } item_t;

    typedef struct packed {
        logic signed [VALUE_BITS-1:0] result_value;
        logic                         was_fixed;
        logic [RAD_W-1:0]             radius_used;
        logic                         gave_up;
    } result_t;

    typedef struct packed {
        logic start;
        logic done;
    } div_ctl_t;

endpackage

// ===== sv/vonf_mem.sv =====
// bin store: one synchronous port, read data registered
// depends on vonf_pkg
module vonf_mem (
    input  logic                                 clk,
    input  logic                                 we,
    input  logic [vonf_pkg::ADDR_W-1:0]          addr,
    input  logic signed [vonf_pkg::VALUE_BITS-1:0] wdata,
    output logic signed [vonf_pkg::VALUE_BITS-1:0] rdata
);

    logic signed [vonf_pkg::VALUE_BITS-1:0] mem [vonf_pkg::DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

// ===== sv/vonf_div.sv =====
// unsigned restoring divider, one quotient bit per cycle
// depends on vonf_pkg
module vonf_div (
    input  logic                         clk,
    input  logic                         rst_n,
    input  vonf_pkg::div_ctl_t           ctl_in,
    output vonf_pkg::div_ctl_t           ctl_out,
    input  logic [vonf_pkg::SUM_W-1:0]   dividend,
    input  logic [vonf_pkg::CNT_W-1:0]   divisor,
    output logic [vonf_pkg::SUM_W-1:0]   quotient
);

    localparam int STEP_W = $clog2(vonf_pkg::SUM_W + 1);

    logic [vonf_pkg::CNT_W:0]   rem_reg, rem_next;
    logic [vonf_pkg::SUM_W-1:0] quo_reg, quo_next;
    logic [STEP_W-1:0]          step_reg, step_next;
    logic                       run_reg, run_next;
    logic                       done_reg, done_next;
    logic [vonf_pkg::CNT_W:0]   shifted;

    always_comb
    begin
        shifted   = {rem_reg[vonf_pkg::CNT_W-1:0], quo_reg[vonf_pkg::SUM_W-1]};
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        step_next = step_reg;
        run_next  = run_reg;
        done_next = 1'b0;
        if (ctl_in.start)
        begin
            rem_next  = '0;
            quo_next  = dividend;
            step_next = STEP_W'(vonf_pkg::SUM_W);
            run_next  = 1'b1;
        end
        else if (run_reg)
        begin
            if (shifted >= {1'b0, divisor})
            begin
                rem_next = shifted - {1'b0, divisor};
                quo_next = {quo_reg[vonf_pkg::SUM_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = shifted;
                quo_next = {quo_reg[vonf_pkg::SUM_W-2:0], 1'b0};
            end
            step_next = step_reg - 1'b1;
            if (step_reg == STEP_W'(1))
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
    end

    assign quotient      = quo_reg;
    assign ctl_out.start = 1'b0;
    assign ctl_out.done  = done_reg;

endmodule

// ===== sv/volume_outlier_neighbour_fill.sv =====
// outlier fill block: bin store, neighbourhood scan sequencer, mean divider
// depends on vonf_pkg, vonf_mem, vonf_div and the assertion header
//
// usage
//   item: a transaction is taken when start is high and busy is low
//   cmd write stores bin_value at (x,y,z) and gives no result
//   cmd query gives one result, shown for one cycle with result_valid high
//   config: cfg_we writes cfg_data to register cfg_index; the user must
//   write only while busy is low, and the block does not enforce it
// sequence
//   write: busy never rises
//   in-range query: the result is registered from the centre bin read
//   out-of-range query: for each radius r tried, one store read per cell of
//   the clipped cube (up to (2r+1)^3 reads, through the single store port),
//   then the sum is finished, divided serially (40 quotient bits, one per
//   cycle) and the mean is tested
//   busy stays high until the result is shown; the next transaction can be
//   taken in the cycle the result is shown
// reset
//   clears control and sets the limits to their defaults; the store is not
//   cleared and must be written before it is read
//   the receiver cannot stall: each result is shown for exactly one cycle
`include "volume_outlier_neighbour_fill_defines.svh"

module volume_outlier_neighbour_fill (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 start,
    output logic                                 busy,
    input  vonf_pkg::item_t                      item,
    output logic                                 result_valid,
    output vonf_pkg::result_t                    result,
    input  logic                                 cfg_we,
    input  logic [vonf_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [vonf_pkg::VALUE_BITS-1:0]      cfg_data
);

    localparam int CW = vonf_pkg::COORD_W;
    localparam int VB = vonf_pkg::VALUE_BITS;
    localparam int RW = vonf_pkg::RAD_W;
    localparam logic [CW-1:0] CMAX = CW'(vonf_pkg::AXIS_BINS - 1);

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_CHK  = 7'b0000010,
        S_SCAN = 7'b0000100,
        S_ACC  = 7'b0001000,
        S_DIVS = 7'b0010000,
        S_DIVW = 7'b0100000,
        S_EVAL = 7'b1000000
    } state_t;

    state_t state_reg, state_next;

    logic signed [VB-1:0] low_reg, high_reg;
    logic [RW-1:0]        maxr_reg;

    logic [CW-1:0] cx_reg, cy_reg, cz_reg;
    logic [CW-1:0] px_reg, py_reg, pz_reg, px_next, py_next, pz_next;
    logic [RW-1:0] r_reg, r_next;
    logic          flag_reg, flag_next;
    logic signed [vonf_pkg::SUM_W-1:0] sum_reg, sum_next;
    logic [vonf_pkg::CNT_W-1:0]        cnt_reg, cnt_next;
    logic signed [VB-1:0]              mean_reg, mean_next;
    logic                              rv_reg, rv_next;
    vonf_pkg::result_t                 res_reg, res_next;

    logic          mem_we;
    logic [vonf_pkg::ADDR_W-1:0] mem_addr;
    logic signed [VB-1:0] mem_rdata;

    vonf_pkg::div_ctl_t div_in, div_out;
    logic [vonf_pkg::SUM_W-1:0] div_dividend, div_q;
    logic signed [vonf_pkg::SUM_W-1:0] div_signed;

    logic [CW-1:0] x0, x1, y0, y1, z0, z1;
    logic [CW-1:0] nx0, ny0, nz0;
    logic          accept, last, whole, is_ctr;
    logic [RW-1:0] rmax;
    logic          ctr_ok, mean_ok;

    function automatic logic [CW-1:0] lo_of(input logic [CW-1:0] c, input logic [RW-1:0] r);
        logic [RW:0] cw;
        cw = (RW+1)'(c);
        lo_of = (cw < (RW+1)'(r)) ? '0 : CW'(cw - (RW+1)'(r));
    endfunction

    function automatic logic [CW-1:0] hi_of(input logic [CW-1:0] c, input logic [RW-1:0] r);
        logic [RW+1:0] s;
        s = (RW+2)'(c) + (RW+2)'(r);
        hi_of = (s > (RW+2)'(CMAX)) ? CMAX : CW'(s);
    endfunction

    vonf_mem u_mem (
        .clk   (clk),
        .we    (mem_we),
        .addr  (mem_addr),
        .wdata (item.bin_value),
        .rdata (mem_rdata)
    );

    vonf_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl_in   (div_in),
        .ctl_out  (div_out),
        .dividend (div_dividend),
        .divisor  (cnt_reg),
        .quotient (div_q)
    );

    assign busy   = (state_reg != S_IDLE);
    assign accept = start && !busy;
    assign mem_we = accept && (item.cmd == vonf_pkg::CMD_WRITE);
    assign mem_addr = (state_reg == S_SCAN) ? {px_reg, py_reg, pz_reg}
                                            : {item.x, item.y, item.z};

    assign x0 = lo_of(cx_reg, r_reg);
    assign x1 = hi_of(cx_reg, r_reg);
    assign y0 = lo_of(cy_reg, r_reg);
    assign y1 = hi_of(cy_reg, r_reg);
    assign z0 = lo_of(cz_reg, r_reg);
    assign z1 = hi_of(cz_reg, r_reg);
    assign nx0 = lo_of(cx_reg, r_reg + 1'b1);
    assign ny0 = lo_of(cy_reg, r_reg + 1'b1);
    assign nz0 = lo_of(cz_reg, r_reg + 1'b1);
    assign last  = (px_reg == x1) && (py_reg == y1) && (pz_reg == z1);
    assign whole = (x0 == '0) && (y0 == '0) && (z0 == '0)
                && (x1 == CMAX) && (y1 == CMAX) && (z1 == CMAX);
    assign is_ctr = (px_reg == cx_reg) && (py_reg == cy_reg) && (pz_reg == cz_reg);
    assign rmax   = (maxr_reg == '0) ? RW'(1) : maxr_reg;
    assign ctr_ok  = (mem_rdata >= low_reg) && (mem_rdata <= high_reg);
    assign mean_ok = (mean_reg >= low_reg) && (mean_reg <= high_reg);

    assign div_dividend = sum_reg[vonf_pkg::SUM_W-1] ? vonf_pkg::SUM_W'(-sum_reg)
                                                     : vonf_pkg::SUM_W'(sum_reg);
    assign div_signed   = sum_reg[vonf_pkg::SUM_W-1] ? -$signed(div_q) : $signed(div_q);
    assign div_in.start = (state_reg == S_DIVS) && (cnt_reg != '0);
    assign div_in.done  = 1'b0;

    always_comb
    begin
        state_next = state_reg;
        px_next    = px_reg;
        py_next    = py_reg;
        pz_next    = pz_reg;
        r_next     = r_reg;
        flag_next  = 1'b0;
        sum_next   = sum_reg;
        cnt_next   = cnt_reg;
        mean_next  = mean_reg;
        rv_next    = 1'b0;
        res_next   = res_reg;
        if (flag_reg)
        begin
            sum_next = sum_reg + vonf_pkg::SUM_W'(mem_rdata);
            cnt_next = cnt_reg + 1'b1;
        end
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept && (item.cmd == vonf_pkg::CMD_QUERY))
                begin
                    state_next = S_CHK;
                end
            end
            S_CHK:
            begin
                if (ctr_ok)
                begin
                    res_next   = '{result_value: mem_rdata, was_fixed: 1'b0,
                                   radius_used: '0, gave_up: 1'b0};
                    rv_next    = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    r_next     = RW'(1);
                    px_next    = lo_of(cx_reg, RW'(1));
                    py_next    = lo_of(cy_reg, RW'(1));
                    pz_next    = lo_of(cz_reg, RW'(1));
                    sum_next   = '0;
                    cnt_next   = '0;
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                flag_next = !is_ctr;
                if (pz_reg != z1)
                begin
                    pz_next = pz_reg + 1'b1;
                end
                else
                begin
                    pz_next = z0;
                    if (py_reg != y1)
                    begin
                        py_next = py_reg + 1'b1;
                    end
                    else
                    begin
                        py_next = y0;
                        px_next = px_reg + 1'b1;
                    end
                end
                if (last)
                begin
                    state_next = S_ACC;
                end
            end
            S_ACC:
            begin
                state_next = S_DIVS;
            end
            S_DIVS:
            begin
                if (cnt_reg == '0)
                begin
                    mean_next  = '0;
                    state_next = S_EVAL;
                end
                else
                begin
                    state_next = S_DIVW;
                end
            end
            S_DIVW:
            begin
                if (div_out.done)
                begin
                    mean_next  = VB'(div_signed);
                    state_next = S_EVAL;
                end
            end
            S_EVAL:
            begin
                if (mean_ok)
                begin
                    res_next   = '{result_value: mean_reg, was_fixed: 1'b1,
                                   radius_used: r_reg, gave_up: 1'b0};
                    rv_next    = 1'b1;
                    state_next = S_IDLE;
                end
                else if ((r_reg >= rmax) || whole)
                begin
                    res_next.was_fixed   = 1'b1;
                    res_next.radius_used = rmax;
                    res_next.gave_up     = 1'b1;
                    if (mean_reg < low_reg)
                    begin
                        res_next.result_value = low_reg;
                    end
                    else if (mean_reg > high_reg)
                    begin
                        res_next.result_value = high_reg;
                    end
                    else
                    begin
                        res_next.result_value = mean_reg;
                    end
                    rv_next    = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    r_next     = r_reg + 1'b1;
                    px_next    = nx0;
                    py_next    = ny0;
                    pz_next    = nz0;
                    sum_next   = '0;
                    cnt_next   = '0;
                    state_next = S_SCAN;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            rv_reg    <= 1'b0;
            flag_reg  <= 1'b0;
            low_reg   <= '0;
            high_reg  <= VB'(65536);
            maxr_reg  <= RW'(31);
        end
        else
        begin
            state_reg <= state_next;
            rv_reg    <= rv_next;
            flag_reg  <= flag_next;
            if (cfg_we)
            begin
                if (cfg_index == vonf_pkg::REG_LOW_LIMIT)
                begin
                    low_reg <= cfg_data;
                end
                else if (cfg_index == vonf_pkg::REG_HIGH_LIMIT)
                begin
                    high_reg <= cfg_data;
                end
                else if (cfg_index == vonf_pkg::REG_MAX_RADIUS)
                begin
                    maxr_reg <= cfg_data[RW-1:0];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cx_reg <= item.x;
            cy_reg <= item.y;
            cz_reg <= item.z;
        end
        px_reg   <= px_next;
        py_reg   <= py_next;
        pz_reg   <= pz_next;
        r_reg    <= r_next;
        sum_reg  <= sum_next;
        cnt_reg  <= cnt_next;
        mean_reg <= mean_next;
        res_reg  <= res_next;
    end

    assign result_valid = rv_reg;
    assign result       = res_reg;

    `VONF_ASSERT_NOW(a_gave_up_fixed, result_valid && result.gave_up, result.was_fixed, "gave_up without fix")
    `VONF_ASSERT_NOW(a_radius_zero, result_valid && !result.was_fixed, result.radius_used == '0, "radius on unfixed result")
    `VONF_ASSERT_NXT(a_query_busy, accept && (item.cmd == vonf_pkg::CMD_QUERY), busy, "query did not start")
    `VONF_ASSERT_NXT(a_write_idle, accept && (item.cmd == vonf_pkg::CMD_WRITE), !busy && !result_valid, "write gave work")

endmodule

// ===== tb/sv/volume_outlier_neighbour_fill_tb.sv =====
// testbench for the outlier fill block: fills a corner block of the volume, then
// directed and random write/query transactions under several limit settings and idle mixes
// depends on vonf_pkg and volume_outlier_neighbour_fill
`timescale 1ns / 1ps

module volume_outlier_neighbour_fill_tb;

    localparam int IDLE_LIMIT = 20000;
    localparam int TAIL_CYCLES = 200;
    localparam int BLK = 7;

    class fill_scoreboard;
        int                 vol [vonf_pkg::DEPTH];
        int                 low_lim;
        int                 high_lim;
        int                 max_rad;
        vonf_pkg::result_t  pending [$];
        int                 errors;
        int                 queries;
        int                 fixes;
        int                 give_ups;

        function new();
            low_lim = 0;
            high_lim = 65536;
            max_rad = 31;
            errors = 0;
            queries = 0;
            fixes = 0;
            give_ups = 0;
        endfunction

        function int addr_of(int x, int y, int z);
            return (x * vonf_pkg::AXIS_BINS + y) * vonf_pkg::AXIS_BINS + z;
        endfunction

        function longint cube_mean(int cx, int cy, int cz, int r, output bit whole);
            longint sum;
            longint cnt;
            int x0, x1, y0, y1, z0, z1;
            int top;
            top = vonf_pkg::AXIS_BINS - 1;
            sum = 0;
            cnt = 0;
            x0 = (cx - r < 0) ? 0 : cx - r;
            y0 = (cy - r < 0) ? 0 : cy - r;
            z0 = (cz - r < 0) ? 0 : cz - r;
            x1 = (cx + r > top) ? top : cx + r;
            y1 = (cy + r > top) ? top : cy + r;
            z1 = (cz + r > top) ? top : cz + r;
            whole = (x0 == 0 && y0 == 0 && z0 == 0 && x1 == top &&
                     y1 == top && z1 == top);
            for (int x = x0; x <= x1; x++)
                for (int y = y0; y <= y1; y++)
                    for (int z = z0; z <= z1; z++)
                    begin
                        if (x == cx && y == cy && z == cz)
                            continue;
                        sum += vol[addr_of(x, y, z)];
                        cnt++;
                    end
            if (cnt == 0)
                return 0;
            return sum / cnt;
        endfunction

        function void note(vonf_pkg::item_t it);
            vonf_pkg::result_t res;
            longint  val;
            longint  mean;
            int      r;
            int      rmax;
            bit      whole;
            bit      gave;
            if (it.cmd == vonf_pkg::CMD_WRITE)
            begin
                vol[addr_of(it.x, it.y, it.z)] = int'(it.bin_value);
                return;
            end
            queries++;
            val = vol[addr_of(it.x, it.y, it.z)];
            res = '0;
            if (val >= low_lim && val <= high_lim)
            begin
                res.result_value = val[vonf_pkg::VALUE_BITS-1:0];
                pending = {pending, res};
                return;
            end
            rmax = (max_rad == 0) ? 1 : max_rad;
            gave = 0;
            mean = 0;
            for (r = 1; r <= rmax; r++)
            begin
                mean = cube_mean(it.x, it.y, it.z, r, whole);
                if (mean >= low_lim && mean <= high_lim)
                    break;
                if (r == rmax || whole)
                begin
                    r = rmax;
                    gave = 1;
                    if (mean < low_lim)
                        mean = low_lim;
                    else if (mean > high_lim)
                        mean = high_lim;
                    break;
                end
            end
            fixes++;
            if (gave)
                give_ups++;
            res.result_value = mean[vonf_pkg::VALUE_BITS-1:0];
            res.was_fixed = 1'b1;
            res.radius_used = r[vonf_pkg::RAD_W-1:0];
            res.gave_up = gave;
            pending = {pending, res};
        endfunction

        function void check(vonf_pkg::result_t got);
            vonf_pkg::result_t want;
            if (pending.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("unexpected result transaction: %p", got);
                return;
            end
            want = pending.pop_front();
            if (got.result_value !== want.result_value || got.was_fixed !== want.was_fixed ||
                got.radius_used !== want.radius_used || got.gave_up !== want.gave_up)
            begin
                errors++;
                if (errors <= 10)
                    $display("mismatch: value %0d/%0d fixed %0b/%0b radius %0d/%0d gave_up %0b/%0b",
                             want.result_value, got.result_value, want.was_fixed, got.was_fixed,
                             want.radius_used, got.radius_used, want.gave_up, got.gave_up);
            end
        endfunction
    endclass

    logic                              clk;
    logic                              rst_n;
    logic                              start;
    logic                              busy;
    vonf_pkg::item_t                   item;
    logic                              result_valid;
    vonf_pkg::result_t                 result;
    logic                              cfg_we;
    logic [vonf_pkg::CFG_IDX_W-1:0]    cfg_index;
    logic [vonf_pkg::VALUE_BITS-1:0]   cfg_data;

    fill_scoreboard sb;
    int             idle_cycles;
    int             idle_pct;

    volume_outlier_neighbour_fill i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .item         (item),
        .result_valid (result_valid),
        .result       (result),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        sb = new();
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((start && !busy) || result_valid)
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (start && !busy)
                sb.note(item);
            if (result_valid)
                sb.check(result);
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("watchdog expired, %0d results outstanding", sb.pending.size());
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    task automatic send(input logic cmd, input int x, input int y, input int z,
                        input int value, input bit use_idle);
        while (use_idle && $urandom_range(99) < idle_pct)
        begin
            start = 1'b0;
            @(negedge clk);
        end
        start = 1'b1;
        item.cmd = cmd;
        item.x = x[4:0];
        item.y = y[4:0];
        item.z = z[4:0];
        item.bin_value = value[vonf_pkg::VALUE_BITS-1:0];
        do
            @(posedge clk);
        while (busy);
        @(negedge clk);
        start = 1'b0;
    endtask

    task automatic drain();
        while (sb.pending.size() != 0 || busy)
            @(negedge clk);
        repeat (5) @(negedge clk);
    endtask

    task automatic write_reg(input logic [vonf_pkg::CFG_IDX_W-1:0] idx, input int value);
        cfg_we = 1'b1;
        cfg_index = idx;
        cfg_data = value[vonf_pkg::VALUE_BITS-1:0];
        @(negedge clk);
        cfg_we = 1'b0;
        case (idx)
            vonf_pkg::REG_LOW_LIMIT:  sb.low_lim = value;
            vonf_pkg::REG_HIGH_LIMIT: sb.high_lim = value;
            default:                  sb.max_rad = value & 63;
        endcase
    endtask

    task automatic set_limits(input int lo, input int hi, input int rad);
        drain();
        write_reg(vonf_pkg::REG_LOW_LIMIT, lo);
        write_reg(vonf_pkg::REG_HIGH_LIMIT, hi);
        write_reg(vonf_pkg::REG_MAX_RADIUS, rad);
    endtask

    function automatic int pick_value();
        int sel;
        sel = $urandom_range(99);
        if (sel < 80)
            return $urandom_range(65536);
        if (sel < 90)
            return $signed($urandom() & 32'hFFFFFF) <<< 8 >>> 8;
        return (sel < 95) ? 8388607 : -8388608;
    endfunction

    // queries stay far enough inside the filled block that every scan reads written bins
    task automatic random_run(input int n);
        int x, y, z, qmax;
        logic cmd;
        qmax = BLK - 1 - ((sb.max_rad == 0) ? 1 : sb.max_rad);
        for (int i = 0; i < n; i++)
        begin
            cmd = $urandom_range(1) ? vonf_pkg::CMD_QUERY : vonf_pkg::CMD_WRITE;
            if (cmd == vonf_pkg::CMD_QUERY)
            begin
                x = $urandom_range(qmax);
                y = $urandom_range(qmax);
                z = $urandom_range(qmax);
            end
            else
            begin
                x = $urandom_range(BLK - 1);
                y = $urandom_range(BLK - 1);
                z = $urandom_range(BLK - 1);
            end
            send(cmd, x, y, z, pick_value(), 1'b1);
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        start = 1'b0;
        item = '0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        idle_cycles = 0;
        idle_pct = 0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // fill the corner block that every later scan stays inside
        set_limits(0, 65536, 1);
        for (int x = 0; x < BLK; x++)
            for (int y = 0; y < BLK; y++)
                for (int z = 0; z < BLK; z++)
                    send(vonf_pkg::CMD_WRITE, x, y, z, pick_value(), 1'b0);

        // directed: corner, extremes, both clamp directions, radius zero, crossed limits
        set_limits(0, 65536, 3);
        send(vonf_pkg::CMD_QUERY, 2, 3, 1, 0, 1'b0);
        send(vonf_pkg::CMD_WRITE, 0, 0, 0, 8388607, 1'b0);
        send(vonf_pkg::CMD_WRITE, 6, 6, 6, -8388608, 1'b0);
        send(vonf_pkg::CMD_WRITE, 3, 3, 3, 65537, 1'b0);
        send(vonf_pkg::CMD_WRITE, 2, 2, 2, 65536, 1'b0);
        send(vonf_pkg::CMD_WRITE, 1, 1, 1, 0, 1'b0);
        send(vonf_pkg::CMD_QUERY, 0, 0, 0, -1, 1'b0);
        send(vonf_pkg::CMD_QUERY, 3, 3, 3, 0, 1'b0);
        send(vonf_pkg::CMD_QUERY, 2, 2, 2, 0, 1'b0);
        send(vonf_pkg::CMD_QUERY, 1, 1, 1, 0, 1'b0);
        set_limits(-100, 1000, 1);
        send(vonf_pkg::CMD_QUERY, 3, 3, 3, 0, 1'b0);
        send(vonf_pkg::CMD_QUERY, 5, 0, 5, 0, 1'b0);
        set_limits(65536, 0, 0);
        send(vonf_pkg::CMD_QUERY, 0, 5, 0, 0, 1'b0);
        send(vonf_pkg::CMD_QUERY, 3, 3, 3, 0, 1'b0);
        set_limits(65536, 0, 3);
        send(vonf_pkg::CMD_QUERY, 3, 3, 3, 0, 1'b0);
        set_limits(-8388608, 8388607, 3);
        send(vonf_pkg::CMD_QUERY, 3, 3, 3, 0, 1'b0);
        send(vonf_pkg::CMD_QUERY, 0, 0, 0, 0, 1'b0);

        set_limits(0, 65536, 1);
        idle_pct = 0;
        random_run(40);
        set_limits(0, 65536, 3);
        idle_pct = 78;
        random_run(40);
        set_limits(65536, 0, 1);
        idle_pct = 12;
        random_run(40);
        set_limits(-1000, 40000, 2);
        idle_pct = 0;
        random_run(40);
        set_limits(-100, 1000, 1);
        idle_pct = 78;
        random_run(40);
        set_limits(0, 65536, 2);
        idle_pct = 12;
        random_run(40);

        drain();
        repeat (TAIL_CYCLES) @(negedge clk);
        $display("covered %0d queries, %0d replaced by neighbour means, %0d clamped",
                 sb.queries, sb.fixes, sb.give_ups);
        $display("normal and crossed limits, radius caps 0 to 3, idle mixes 0/12/78, %0d errors",
                 sb.errors + sb.pending.size());
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
